// ----- sv/mmtb_pkg.sv -----
package mmtb_pkg;

  localparam int MAX_SEGMENTS      = 64;
  localparam int TICKS_PER_QUARTER = 705600;
  localparam int BEATS_PER_WHOLE   = 4;

  localparam int ADDR_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);

  localparam int TPB_W  = 38;
  localparam int NUM_W  = 16;
  localparam int DEN_W  = 9;
  localparam int PROD_W = 64 + TPB_W;
  localparam int ACC_W  = PROD_W + 3;

  localparam logic [63:0] WHOLE_TICKS = 64'(BEATS_PER_WHOLE) * 64'(TICKS_PER_QUARTER);

  localparam logic [1:0] K_CLEAR  = 2'd0;
  localparam logic [1:0] K_APPEND = 2'd1;
  localparam logic [1:0] K_T2B    = 2'd2;
  localparam logic [1:0] K_B2T    = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_MAP    = 3'd1;
  localparam logic [2:0] ST_NO_ZERO   = 3'd2;
  localparam logic [2:0] ST_BAD_SIG   = 3'd3;
  localparam logic [2:0] ST_UNORDERED = 3'd4;
  localparam logic [2:0] ST_OFF_BAR   = 3'd5;
  localparam logic [2:0] ST_RANGE     = 3'd6;
  localparam logic [2:0] ST_FULL      = 3'd7;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [63:0] tick;
    logic signed [63:0] bar;
    logic signed [63:0] bar_offset;
    logic [15:0]        numerator;
    logic [15:0]        denominator;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [63:0] result_bar;
    logic [TPB_W-1:0]   result_offset;
    logic signed [63:0] result_tick;
    logic [NUM_W-1:0]   meter_numerator;
    logic [DEN_W-1:0]   meter_denominator;
  } rsp_t;

  typedef struct packed {
    logic signed [63:0] base_tick;
    logic signed [63:0] base_bar;
    logic [TPB_W-1:0]   tpb;
    logic [NUM_W-1:0]   num;
    logic [DEN_W-1:0]   den;
  } seg_t;

endpackage

// ----- sv/meter_map_tick_bar_converter_core.sv -----
// Channel  Handshake             Payload  Direction
// req      req_valid/req_ready   req_t    in
// rsp      rsp_valid/rsp_ready   rsp_t    out
//
// One transaction is worked on at a time. A clear or an item rejected on entry
// goes straight to the response; the first append is written at once; an
// unordered append fails after one table read; any other append reads the table,
// runs the 64 divider steps and, unless it fails, is written. Tick to bar and bar
// to tick read the table once per segment, then run the 64-step divider or the
// shift-add multiplier; bar to tick then sums the result in a final step. The
// block is ready for the next request as soon as the response is presented. Reset is
// synchronous and needs no clearing pass. A stalled rsp holds the finished
// result while the block takes and works the next request, then stalls req.
module meter_map_tick_bar_converter_core import mmtb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SCAN  = 8'b0000_0010,
    S_ADIV  = 8'b0000_0100,
    S_QDIV  = 8'b0000_1000,
    S_QMUL  = 8'b0001_0000,
    S_FIN   = 8'b0010_0000,
    S_WRITE = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t                  state;
  req_t                    item;
  rsp_t                    res;
  seg_t                    sel;
  seg_t                    rd_data;
  seg_t                    wr_data;
  logic [CNT_W-1:0]        count;
  logic                    poisoned;
  logic [CNT_W-1:0]        iss;
  logic [CNT_W-1:0]        scan_n;
  logic                    pend;
  logic                    pend_first;
  logic                    neg;
  logic [TPB_W-1:0]        tpb_new;
  logic signed [63:0]      new_bar;
  logic signed [ACC_W-1:0] acc;

  logic                    accept;
  logic                    issue;
  logic                    hit;
  logic                    we;
  logic [ADDR_W-1:0]       addr;
  logic                    sig_ok;
  logic [3:0]              den_log;
  logic [63:0]             whole_div;
  logic [TPB_W-1:0]        tpb_calc;
  logic [63:0]             delta;
  logic [63:0]             mag;
  logic                    scan_end;
  logic                    div_start;
  logic                    mul_start;
  logic                    div_done;
  logic [63:0]             quo;
  logic [TPB_W-1:0]        rem;
  logic                    mul_done;
  logic [PROD_W-1:0]       prod;
  logic [64:0]             bar_sum;
  logic [65:0]             q_signed;
  logic [65:0]             t2b_sum;
  logic [TPB_W-1:0]        r_floor;
  logic signed [ACC_W-1:0] b2t_sum;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;

  // Signature check and ticks per bar of the incoming point.
  always_comb begin
    den_log = '0;
    for (int i = 0; i < 16; i++) begin
      if (req.denominator[i]) begin
        den_log = 4'(i);
      end
    end
    sig_ok = (req.numerator != '0) && (req.denominator != '0) &&
             ((req.denominator & (req.denominator - 16'd1)) == '0) &&
             ({48'd0, req.denominator} <= WHOLE_TICKS) &&
             ((WHOLE_TICKS[15:0] & (req.denominator - 16'd1)) == '0);
    whole_div = WHOLE_TICKS >> den_log;
    tpb_calc  = TPB_W'({16'd0, req.numerator} * {16'd0, whole_div[31:0]});
  end

  assign issue    = (state == S_SCAN) && (iss < scan_n);
  assign scan_end = (state == S_SCAN) && !issue && !pend;
  assign we       = (state == S_WRITE);
  assign hit      = (item.kind == K_T2B) ? (rd_data.base_tick <= item.tick)
                                         : (rd_data.base_bar <= item.bar);

  always_comb begin
    if (we) begin
      addr = count[ADDR_W-1:0];
    end else if (item.kind == K_APPEND) begin
      addr = ADDR_W'(count - CNT_W'(1));
    end else begin
      addr = iss[ADDR_W-1:0];
    end
    wr_data.base_tick = item.tick;
    wr_data.base_bar  = new_bar;
    wr_data.tpb       = tpb_new;
    wr_data.num       = item.numerator;
    wr_data.den       = DEN_W'(item.denominator);
  end

  // For an append that is in order the distance is positive; for a query it may be negative.
  always_comb begin
    if (item.kind == K_B2T) begin
      delta = item.bar - sel.base_bar;
    end else begin
      delta = item.tick - sel.base_tick;
    end
    mag = delta[63] ? (64'd0 - delta) : delta;
  end

  assign div_start = scan_end && (item.kind != K_B2T) &&
                     !((item.kind == K_APPEND) && (item.tick <= sel.base_tick));
  assign mul_start = scan_end && (item.kind == K_B2T);

  always_comb begin
    bar_sum  = {1'b0, sel.base_bar} + {1'b0, quo};
    // Floor division: a negative quotient with a remainder rounds down.
    if (neg) begin
      q_signed = (rem != '0) ? ~{2'b00, quo} : (66'd0 - {2'b00, quo});
      r_floor  = (rem != '0) ? (sel.tpb - rem) : '0;
    end else begin
      q_signed = {2'b00, quo};
      r_floor  = rem;
    end
    t2b_sum = {{2{sel.base_bar[63]}}, sel.base_bar} + q_signed;
    b2t_sum = acc + ACC_W'($signed(sel.base_tick)) + ACC_W'($signed(item.bar_offset));
  end

  mmtb_seg_ram u_ram (
    .clk   (clk),
    .we    (we),
    .addr  (addr),
    .wdata (wr_data),
    .rdata (rd_data)
  );

  mmtb_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mag),
    .divisor  (sel.tpb),
    .done     (div_done),
    .quo      (quo),
    .rem      (rem)
  );

  mmtb_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mag),
    .b     (sel.tpb),
    .done  (mul_done),
    .prod  (prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      poisoned  <= 1'b0;
      pend      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      // In S_DONE the output register is refilled or left as it is.
      if (rsp_valid && rsp_ready && (state != S_DONE)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            item    <= req;
            res     <= '0;
            tpb_new <= tpb_calc;
            new_bar <= '0;
            iss     <= '0;
            pend    <= 1'b0;
            unique case (req.kind)
              K_CLEAR: begin
                count    <= '0;
                poisoned <= 1'b0;
                state    <= S_DONE;
              end
              K_APPEND: begin
                scan_n <= CNT_W'(1);
                if (poisoned) begin
                  res.status <= ST_NO_MAP;
                  state      <= S_DONE;
                end else if ((count == '0) && (req.tick != '0)) begin
                  res.status <= ST_NO_ZERO;
                  poisoned   <= 1'b1;
                  state      <= S_DONE;
                end else if (!sig_ok) begin
                  res.status <= ST_BAD_SIG;
                  poisoned   <= 1'b1;
                  state      <= S_DONE;
                end else if (count == '0) begin
                  state <= S_WRITE;
                end else begin
                  state <= S_SCAN;
                end
              end
              default: begin
                scan_n <= count;
                if (poisoned || (count == '0)) begin
                  res.status <= ST_NO_MAP;
                  state      <= S_DONE;
                end else begin
                  state <= S_SCAN;
                end
              end
            endcase
          end
        end
        S_SCAN: begin
          pend       <= issue;
          pend_first <= (iss == '0);
          if (issue) begin
            iss <= iss + CNT_W'(1);
          end
          if (pend && (pend_first || hit)) begin
            sel <= rd_data;
          end
          if (scan_end) begin
            neg <= delta[63];
            if (item.kind != K_APPEND) begin
              res.meter_numerator   <= sel.num;
              res.meter_denominator <= sel.den;
            end
            priority case (1'b1)
              mul_start: state <= S_QMUL;
              div_start: state <= (item.kind == K_APPEND) ? S_ADIV : S_QDIV;
              default: begin
                res.status <= ST_UNORDERED;
                poisoned   <= 1'b1;
                state      <= S_DONE;
              end
            endcase
          end
        end
        S_ADIV: begin
          if (div_done) begin
            res.meter_numerator   <= '0;
            res.meter_denominator <= '0;
            if (rem != '0) begin
              res.status <= ST_OFF_BAR;
              poisoned   <= 1'b1;
              state      <= S_DONE;
            end else if (bar_sum[64] || bar_sum[63]) begin
              res.status <= ST_RANGE;
              poisoned   <= 1'b1;
              state      <= S_DONE;
            end else if (count >= CNT_W'(MAX_SEGMENTS)) begin
              res.status <= ST_FULL;
              poisoned   <= 1'b1;
              state      <= S_DONE;
            end else begin
              new_bar <= bar_sum[63:0];
              state   <= S_WRITE;
            end
          end
        end
        S_QDIV: begin
          if (div_done) begin
            res.result_offset <= r_floor;
            if ((t2b_sum[65:63] == 3'b000) || (t2b_sum[65:63] == 3'b111)) begin
              res.result_bar <= t2b_sum[63:0];
            end else if (t2b_sum[65]) begin
              res.result_bar <= {1'b1, 63'd0};
            end else begin
              res.result_bar <= {1'b0, {63{1'b1}}};
            end
            state <= S_DONE;
          end
        end
        S_QMUL: begin
          if (mul_done) begin
            acc   <= neg ? -$signed(ACC_W'(prod)) : $signed(ACC_W'(prod));
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if ((b2t_sum[ACC_W-1:63] == '0) || (&b2t_sum[ACC_W-1:63])) begin
            res.result_tick <= b2t_sum[63:0];
          end else if (b2t_sum[ACC_W-1]) begin
            res.result_tick <= {1'b1, 63'd0};
          end else begin
            res.result_tick <= {1'b0, {63{1'b1}}};
          end
          state <= S_DONE;
        end
        S_WRITE: begin
          count <= count + CNT_W'(1);
          state <= S_DONE;
        end
        S_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp       <= res;
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_SEGMENTS))
    else $error("segment count beyond table size");

  a_write_room: assert property (@(posedge clk) disable iff (rst)
    we |-> (count < CNT_W'(MAX_SEGMENTS)) && !poisoned)
    else $error("table write with no room or poisoned table");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    accept && (req.kind == K_CLEAR) |=> (count == '0) && !poisoned)
    else $error("clear did not empty the table");
`endif

endmodule

// ----- sv/mmtb_seg_ram.sv -----
module mmtb_seg_ram import mmtb_pkg::*; (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  seg_t              wdata,
  output seg_t              rdata
);

  seg_t mem [MAX_SEGMENTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- sv/mmtb_div.sv -----
module mmtb_div import mmtb_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [63:0]      dividend,
  input  logic [TPB_W-1:0] divisor,
  output logic             done,
  output logic [63:0]      quo,
  output logic [TPB_W-1:0] rem
);

  logic             busy;
  logic [5:0]       cnt;
  logic [TPB_W-1:0] dsr;
  logic [TPB_W:0]   r_sh;
  logic [TPB_W:0]   r_sub;
  logic             take;

  // Restoring division, one quotient bit per cycle, MSB first.
  always_comb begin
    r_sh  = {rem, quo[63]};
    r_sub = r_sh - {1'b0, dsr};
    take  = (r_sh >= {1'b0, dsr});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        quo  <= dividend;
        rem  <= '0;
        dsr  <= divisor;
      end else if (busy) begin
        quo <= {quo[62:0], take};
        rem <= take ? r_sub[TPB_W-1:0] : r_sh[TPB_W-1:0];
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- sv/mmtb_mul.sv -----
module mmtb_mul import mmtb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [63:0]       a,
  input  logic [TPB_W-1:0]  b,
  output logic              done,
  output logic [PROD_W-1:0] prod
);

  logic              busy;
  logic [5:0]        cnt;
  logic [PROD_W-1:0] mcand;
  logic [63:0]       mplier;

  // Shift-and-add, one multiplier bit per cycle, LSB first.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        cnt    <= '0;
        prod   <= '0;
        mcand  <= PROD_W'(b);
        mplier <= a;
      end else if (busy) begin
        if (mplier[0]) begin
          prod <= prod + mcand;
        end
        mcand  <= {mcand[PROD_W-2:0], 1'b0};
        mplier <= {1'b0, mplier[63:1]};
        cnt    <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- dv/meter_map_tick_bar_converter_core_test.sv -----
`timescale 1ns / 1ps

module meter_map_tick_bar_converter_core_test;
  import mmtb_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int ITEM_TARGET    = 850;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  meter_map_tick_bar_converter_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always #5 clk = ~clk;

  // Shadow meter table for prediction.
  logic signed [63:0] tbl_tick [MAX_SEGMENTS];
  logic signed [63:0] tbl_bar  [MAX_SEGMENTS];
  logic [TPB_W-1:0]   tbl_tpb  [MAX_SEGMENTS];
  logic [NUM_W-1:0]   tbl_num  [MAX_SEGMENTS];
  logic [DEN_W-1:0]   tbl_den  [MAX_SEGMENTS];
  int                 tbl_count;
  bit                 tbl_poisoned;

  req_t pending_req[$];
  rsp_t expected_rsp[$];
  int   error_count;
  int   cycle_count;
  int   quiet_cycles;
  int   num_items;

  function automatic bit meter_valid(logic [15:0] num, logic [15:0] den);
    logic [63:0] d;
    d = 64'(den);
    if (num == 0 || d == 0) return 1'b0;
    if ((d & (d - 64'd1)) != 0) return 1'b0;
    return (d <= WHOLE_TICKS) && (WHOLE_TICKS % d == 0);
  endfunction

  function automatic rsp_t convert(req_t it);
    rsp_t               o;
    logic [2:0]         st;
    logic [63:0]        gap;
    logic [63:0]        added;
    logic [63:0]        room;
    logic signed [63:0] new_bar;
    logic signed [63:0] delta;
    logic signed [63:0] d;
    logic signed [63:0] q;
    logic signed [63:0] r;
    logic signed [64:0] sum_bar;
    logic signed [63:0] bars;
    logic signed [127:0] a;
    logic signed [127:0] b;
    logic signed [127:0] c;
    logic signed [127:0] e;
    logic signed [127:0] acc;
    int                 last;
    int                 s;
    o = '0;
    if (it.kind == K_CLEAR) begin
      tbl_count = 0;
      tbl_poisoned = 1'b0;
      return o;
    end
    if (it.kind == K_APPEND) begin
      st = ST_OK;
      new_bar = '0;
      if (tbl_poisoned) begin
        o.status = ST_NO_MAP;
        return o;
      end
      if (tbl_count == 0 && it.tick != 0) begin
        st = ST_NO_ZERO;
      end else if (!meter_valid(it.numerator, it.denominator)) begin
        st = ST_BAD_SIG;
      end else if (tbl_count > 0) begin
        last = tbl_count - 1;
        if (it.tick <= tbl_tick[last]) begin
          st = ST_UNORDERED;
        end else begin
          gap = it.tick - tbl_tick[last];
          if (gap % 64'(tbl_tpb[last]) != 0) begin
            st = ST_OFF_BAR;
          end else begin
            added = gap / 64'(tbl_tpb[last]);
            room = 64'h7FFF_FFFF_FFFF_FFFF - tbl_bar[last];
            if (added > room) st = ST_RANGE;
            else new_bar = tbl_bar[last] + added;
          end
        end
      end
      if (st == ST_OK && tbl_count >= MAX_SEGMENTS) st = ST_FULL;
      if (st != ST_OK) begin
        tbl_poisoned = 1'b1;
        o.status = st;
        return o;
      end
      tbl_tick[tbl_count] = it.tick;
      tbl_bar[tbl_count]  = new_bar;
      tbl_tpb[tbl_count]  = TPB_W'(64'(it.numerator) * (WHOLE_TICKS / 64'(it.denominator)));
      tbl_num[tbl_count]  = it.numerator;
      tbl_den[tbl_count]  = it.denominator[DEN_W-1:0];
      tbl_count++;
      return o;
    end
    if (tbl_poisoned || tbl_count == 0) begin
      o.status = ST_NO_MAP;
      return o;
    end
    s = 0;
    if (it.kind == K_T2B) begin
      for (int i = 1; i < tbl_count; i++)
        if (tbl_tick[i] <= it.tick) s = i;
      delta = it.tick - tbl_tick[s];
      d = tbl_tpb[s];
      q = delta / d;
      r = delta % d;
      if (r < 0) begin
        q = q - 1;
        r = r + d;
      end
      sum_bar = tbl_bar[s];
      sum_bar = sum_bar + q;
      if (sum_bar[64] != sum_bar[63])
        o.result_bar = sum_bar[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      else
        o.result_bar = sum_bar[63:0];
      o.result_offset = r[TPB_W-1:0];
    end else begin
      for (int i = 1; i < tbl_count; i++)
        if (tbl_bar[i] <= it.bar) s = i;
      bars = it.bar - tbl_bar[s];
      a = bars;
      b = {90'd0, tbl_tpb[s]};
      c = tbl_tick[s];
      e = it.bar_offset;
      acc = a * b + c + e;
      if (acc[127:63] == '0 || acc[127:63] == '1)
        o.result_tick = acc[63:0];
      else
        o.result_tick = acc[127] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    end
    o.meter_numerator   = tbl_num[s];
    o.meter_denominator = tbl_den[s];
    return o;
  endfunction

  task automatic push_item(logic [1:0] kind, logic [63:0] tick, logic [63:0] bar,
                           logic [63:0] tib, logic [15:0] num, logic [15:0] den);
    req_t it;
    it.kind = kind;
    it.tick = tick;
    it.bar = bar;
    it.bar_offset = tib;
    it.numerator = num;
    it.denominator = den;
    expected_rsp = {expected_rsp, convert(it)};
    pending_req = {pending_req, it};
    num_items++;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Appends a well-formed point k bars after the last one, or the first point.
  task automatic append_good(int k);
    logic [15:0] num;
    logic [15:0] den;
    logic [63:0] t;
    num = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535))
                                      : 16'($urandom_range(1, 16));
    den = 16'(1) << $urandom_range(0, 8);
    if (tbl_count == 0) t = 0;
    else t = tbl_tick[tbl_count-1] + 64'(k) * 64'(tbl_tpb[tbl_count-1]);
    push_item(K_APPEND, t, rand64(), rand64(), num, den);
  endtask

  task automatic push_query();
    int s;
    logic [63:0] v;
    logic [63:0] tib;
    s = (tbl_count > 0) ? $urandom_range(0, tbl_count - 1) : 0;
    if ($urandom_range(0, 1) == 0) begin
      if ($urandom_range(0, 9) == 0 || tbl_count == 0) v = rand64();
      else v = tbl_tick[s] + 64'($signed($urandom_range(0, 4000000)) - 1000000)
               * 64'($urandom_range(1, 50000));
      push_item(K_T2B, v, rand64(), rand64(), 16'($urandom), 16'($urandom));
    end else begin
      if ($urandom_range(0, 9) == 0 || tbl_count == 0) v = rand64();
      else v = tbl_bar[s] + 64'($signed($urandom_range(0, 20)) - 5);
      tib = ($urandom_range(0, 4) == 0) ? rand64() : 64'($urandom_range(0, 100000));
      push_item(K_B2T, rand64(), v, tib, 16'($urandom), 16'($urandom));
    end
  endtask

  task automatic build_stimulus();
    int r;
    int k;
    // Directed part: the no-map, no-zero, bad-signature, unordered and off-bar statuses, every kind, field extremes.
    push_item(K_B2T, 0, 0, 0, 0, 0);
    push_item(K_APPEND, 64'd5, 0, 0, 16'd4, 16'd4);
    push_item(K_APPEND, 0, 0, 0, 16'd4, 16'd4);
    push_item(K_T2B, 0, 0, 0, 0, 0);
    push_item(K_CLEAR, '1, '1, '1, '1, '1);
    push_item(K_APPEND, 0, 0, 0, 16'd0, 16'd4);
    push_item(K_CLEAR, 0, 0, 0, 0, 0);
    push_item(K_APPEND, 0, 0, 0, 16'd3, 16'd6);
    push_item(K_CLEAR, 0, 0, 0, 0, 0);
    push_item(K_APPEND, 0, 0, 0, 16'd3, 16'd512);
    push_item(K_CLEAR, 0, 0, 0, 0, 0);
    push_item(K_APPEND, 0, '1, '1, 16'hFFFF, 16'd256);
    push_item(K_APPEND, 0, 0, 0, 16'd4, 16'd4);
    push_item(K_CLEAR, 0, 0, 0, 0, 0);
    push_item(K_APPEND, 0, 0, 0, 16'd1, 16'd256);
    push_item(K_APPEND, 64'd11025 * 64'd3 + 64'd1, 0, 0, 16'd4, 16'd4);
    push_item(K_CLEAR, 0, 0, 0, 0, 0);
    push_item(K_APPEND, 0, 0, 0, 16'd1, 16'd256);
    push_item(K_APPEND, 64'd11025 * 64'd7, 0, 0, 16'hFFFF, 16'd1);
    push_item(K_T2B, 64'h8000_0000_0000_0000, 0, 0, 0, 0);
    push_item(K_T2B, 64'h7FFF_FFFF_FFFF_FFFF, 0, 0, 0, 0);
    push_item(K_B2T, 0, 64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF, 0, 0);
    push_item(K_B2T, 0, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 0, 0);
    push_item(K_B2T, 0, 64'd3, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0);
    push_item(K_T2B, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0, 0);
    while (num_items < ITEM_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        push_item(K_CLEAR, rand64(), rand64(), rand64(), 16'($urandom), 16'($urandom));
      end else if (r < 45) begin
        if (tbl_poisoned || tbl_count == 0) begin
          push_item(K_CLEAR, 0, 0, 0, 0, 0);
          append_good(0);
        end else begin
          k = $urandom_range(1, 4);
          if ($urandom_range(0, 3) == 0 && tbl_tick[tbl_count-1] < 64'sh1000_0000_0000_0000)
            k = $urandom_range(1, 1 << 20);
          append_good(k);
        end
      end else if (r < 50) begin
        if ($urandom_range(0, 1) == 0 && tbl_count > 0)
          push_item(K_APPEND, tbl_tick[tbl_count-1] + 64'($urandom_range(0, 3)) *
                    64'(tbl_tpb[tbl_count-1]) + 64'($urandom_range(0, 2)),
                    rand64(), rand64(), 16'($urandom), 16'($urandom));
        else
          push_item(K_APPEND, rand64(), rand64(), rand64(), 16'($urandom), 16'($urandom));
      end else if (r < 52) begin
        // Fill the table to the brim and push one point past it.
        push_item(K_CLEAR, 0, 0, 0, 0, 0);
        append_good(0);
        for (int i = 1; i <= MAX_SEGMENTS; i++) append_good($urandom_range(1, 2));
        push_item(K_CLEAR, 0, 0, 0, 0, 0);
      end else begin
        push_query();
      end
    end
  endtask

  task automatic report(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch in %s at cycle %0d: got %h expected %h", field, cycle_count, got, want);
    error_count++;
  endtask

  // Driver.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      req <= '0;
    end else if (!req_valid || req_ready) begin
      if (pending_req.size() > 0 &&
          !((cycle_count < 10000 || cycle_count > 30000) && $urandom_range(0, 99) < 17)) begin
        req_valid <= 1'b1;
        req <= pending_req.pop_front();
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Receiver side; a long hold-off lets the block back up into its input.
  int hold_left;
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
      hold_left <= 0;
    end else begin
      if (cycle_count == 3000) hold_left <= 1500;
      else if (hold_left > 0) hold_left <= hold_left - 1;
      rsp_ready <= (hold_left == 0) && cycle_count != 3000 &&
                   !((cycle_count < 10000 || cycle_count > 30000) &&
                     $urandom_range(0, 99) < 17);
    end
  end

  // Monitor.
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_rsp.size() == 0) begin
        $display("unexpected transaction at cycle %0d", cycle_count);
        error_count++;
      end else begin
        want = expected_rsp.pop_front();
        if (rsp.status !== want.status) report("status", 64'(rsp.status), 64'(want.status));
        if (rsp.result_bar !== want.result_bar)
          report("result_bar", rsp.result_bar, want.result_bar);
        if (rsp.result_offset !== want.result_offset)
          report("result_offset", 64'(rsp.result_offset), 64'(want.result_offset));
        if (rsp.result_tick !== want.result_tick)
          report("result_tick", rsp.result_tick, want.result_tick);
        if (rsp.meter_numerator !== want.meter_numerator)
          report("meter_numerator", 64'(rsp.meter_numerator), 64'(want.meter_numerator));
        if (rsp.meter_denominator !== want.meter_denominator)
          report("meter_denominator", 64'(rsp.meter_denominator),
                 64'(want.meter_denominator));
      end
    end
  end

  // Watchdog on cycles without any accepted transaction.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    error_count = 0;
    cycle_count = 0;
    quiet_cycles = 0;
    num_items = 0;
    tbl_count = 0;
    tbl_poisoned = 1'b0;
    build_stimulus();
    // Expected responses are all predicted up front; only the queues matter now.
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    wait (pending_req.size() == 0 && !req_valid && expected_rsp.size() == 0);
    repeat (200) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- meter_map_tick_bar_converter_core.f -----
sv/mmtb_pkg.sv
sv/mmtb_seg_ram.sv
sv/mmtb_div.sv
sv/mmtb_mul.sv
sv/meter_map_tick_bar_converter_core.sv
dv/meter_map_tick_bar_converter_core_test.sv
